>>> rtl/bwv_pkg.sv
// ----------------------------------------------------------------------------
// bwv_pkg
// Shared types, constants and rate helpers for the bandwidth vote block.
// ----------------------------------------------------------------------------
package bwv_pkg;

    localparam int COUNT_W     = 16;
    localparam int SHIFT_W     = 5;
    localparam int THRESH_W    = 16;
    localparam int DELAY_W     = 16;
    localparam int LEVELS_W    = 32;
    localparam int LEVEL_W     = 16;
    localparam int CHANNEL_W   = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int RATE_W      = 28;

    localparam int SKB_BYTES    = 1536;
    localparam int FRAG_BYTES   = 1920;
    localparam int MBPS_TO_BPMS = 125;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCALE_DOWN_DELAY = 3'd0,
        REG_RX_HIGH_THRESH   = 3'd1,
        REG_RX_LOW_THRESH    = 3'd2,
        REG_TX_HIGH_THRESH   = 3'd3,
        REG_TX_LOW_THRESH    = 3'd4,
        REG_RX_VOTE_LEVELS   = 3'd5,
        REG_TX_VOTE_LEVELS   = 3'd6,
        REG_VOTE_CHANNEL_ID  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic                enable;
        logic [SHIFT_W-1:0]  tick_shift;
        logic [COUNT_W-1:0]  rx_normal_count;
        logic [COUNT_W-1:0]  rx_frag_count;
        logic [COUNT_W-1:0]  tx_desc_count;
    } tick_item_t;

    typedef struct packed {
        logic [THRESH_W-1:0] high_thresh;
        logic [THRESH_W-1:0] low_thresh;
        logic [LEVELS_W-1:0] levels;
    } path_cfg_t;

    typedef struct packed {
        logic [DELAY_W-1:0] scale_down_delay;
        path_cfg_t          rx;
        path_cfg_t          tx;
    } vote_cfg_t;

    function automatic logic [RATE_W-1:0] mbps_to_bpms(input logic [THRESH_W-1:0] mbps);
        return RATE_W'(mbps) * RATE_W'(MBPS_TO_BPMS);
    endfunction

    function automatic logic [RATE_W-1:0] rx_rate(input logic [COUNT_W-1:0] normal,
                                                  input logic [COUNT_W-1:0] frag);
        return RATE_W'(normal) * RATE_W'(SKB_BYTES) + RATE_W'(frag) * RATE_W'(FRAG_BYTES);
    endfunction

    function automatic logic [RATE_W-1:0] tx_rate(input logic [COUNT_W-1:0] desc);
        logic [RATE_W-1:0] bytes;
        bytes = RATE_W'(desc) * RATE_W'(SKB_BYTES);
        return bytes >> 1;
    endfunction

endpackage

>>> rtl/bwv_if.sv
// ----------------------------------------------------------------------------
// bwv_if
// Channel interfaces for ticks, votes and configuration writes.
// ----------------------------------------------------------------------------
interface bwv_tick_if;
    logic                          valid;
    logic                          ready;
    logic                          enable;
    logic [bwv_pkg::SHIFT_W-1:0]   tick_shift;
    logic [bwv_pkg::COUNT_W-1:0]   rx_normal_count;
    logic [bwv_pkg::COUNT_W-1:0]   rx_frag_count;
    logic [bwv_pkg::COUNT_W-1:0]   tx_desc_count;

    modport source (
        output valid, enable, tick_shift, rx_normal_count, rx_frag_count, tx_desc_count,
        input  ready
    );
    modport sink (
        input  valid, enable, tick_shift, rx_normal_count, rx_frag_count, tx_desc_count,
        output ready
    );
endinterface

interface bwv_vote_if #(
    parameter int VOTE_WIDTH = 16
);
    logic                            valid;
    logic                            ready;
    logic                            vote_issued;
    logic [VOTE_WIDTH-1:0]           vote_bw;
    logic [bwv_pkg::CHANNEL_W-1:0]   vote_channel;

    modport source (
        output valid, vote_issued, vote_bw, vote_channel,
        input  ready
    );
    modport sink (
        input  valid, vote_issued, vote_bw, vote_channel,
        output ready
    );
endinterface

interface bwv_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bwv_pkg::CFG_INDEX_W-1:0]  index;
    logic [bwv_pkg::CFG_DATA_W-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> rtl/bwv_path.sv
// ----------------------------------------------------------------------------
// bwv_path
// Threshold hysteresis for one traffic path: picks high, low or held vote.
// ----------------------------------------------------------------------------
module bwv_path #(
    parameter int VOTE_WIDTH = 16
) (
    input  logic [bwv_pkg::RATE_W-1:0] rate,
    input  logic [VOTE_WIDTH-1:0]      prev_vote,
    input  bwv_pkg::path_cfg_t         cfg,
    output logic [VOTE_WIDTH-1:0]      vote_dec,
    output logic [VOTE_WIDTH-1:0]      vote_low
);

    localparam int LVL_W = (VOTE_WIDTH < bwv_pkg::LEVEL_W) ? VOTE_WIDTH : bwv_pkg::LEVEL_W;

    logic [VOTE_WIDTH-1:0]      vote_high;
    logic [bwv_pkg::RATE_W-1:0] high_bpms;
    logic [bwv_pkg::RATE_W-1:0] low_bpms;

    assign vote_high = VOTE_WIDTH'(cfg.levels[bwv_pkg::LEVEL_W +: LVL_W]);
    assign vote_low  = VOTE_WIDTH'(cfg.levels[0 +: LVL_W]);
    assign high_bpms = bwv_pkg::mbps_to_bpms(cfg.high_thresh);
    assign low_bpms  = bwv_pkg::mbps_to_bpms(cfg.low_thresh);

    // high test wins when thresholds cross
    always_comb
    begin
        if (rate > high_bpms)
        begin
            vote_dec = vote_high;
        end
        else if (rate < low_bpms)
        begin
            vote_dec = vote_low;
        end
        else
        begin
            vote_dec = prev_vote;
        end
    end

endmodule

>>> rtl/bwv_vote_ctrl.sv
// ----------------------------------------------------------------------------
// bwv_vote_ctrl
// Vote state: path votes, current vote and scale-down countdown.
// ----------------------------------------------------------------------------
module bwv_vote_ctrl #(
    parameter int VOTE_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  bwv_pkg::tick_item_t   item,
    input  bwv_pkg::vote_cfg_t    cfg,
    output logic                  issued,
    output logic [VOTE_WIDTH-1:0] vote_bw
);

    logic [VOTE_WIDTH-1:0]       rx_vote_reg, rx_vote_next;
    logic [VOTE_WIDTH-1:0]       tx_vote_reg, tx_vote_next;
    logic [VOTE_WIDTH-1:0]       cur_vote_reg, cur_vote_next;
    logic [bwv_pkg::DELAY_W-1:0] countdown_reg, countdown_next;

    logic [VOTE_WIDTH-1:0]       rx_dec, rx_low, tx_dec, tx_low, target;
    logic [bwv_pkg::DELAY_W-1:0] shifted, reload;
    logic [bwv_pkg::RATE_W-1:0]  rx_rate, tx_rate;

    assign rx_rate = bwv_pkg::rx_rate(item.rx_normal_count, item.rx_frag_count);
    assign tx_rate = bwv_pkg::tx_rate(item.tx_desc_count);

    bwv_path #(.VOTE_WIDTH(VOTE_WIDTH)) u_rx_path (
        .rate      (rx_rate),
        .prev_vote (rx_vote_reg),
        .cfg       (cfg.rx),
        .vote_dec  (rx_dec),
        .vote_low  (rx_low)
    );

    bwv_path #(.VOTE_WIDTH(VOTE_WIDTH)) u_tx_path (
        .rate      (tx_rate),
        .prev_vote (tx_vote_reg),
        .cfg       (cfg.tx),
        .vote_dec  (tx_dec),
        .vote_low  (tx_low)
    );

    assign target  = (rx_dec > tx_dec) ? rx_dec : tx_dec;
    assign shifted = cfg.scale_down_delay >> item.tick_shift;
    assign reload  = (shifted == '0) ? bwv_pkg::DELAY_W'(1) : shifted;

    always_comb
    begin
        rx_vote_next   = rx_vote_reg;
        tx_vote_next   = tx_vote_reg;
        cur_vote_next  = cur_vote_reg;
        countdown_next = countdown_reg;
        issued         = 1'b0;
        if (!item.enable)
        begin
            issued         = (cur_vote_reg != '0);
            cur_vote_next  = '0;
            countdown_next = '0;
            rx_vote_next   = rx_low;
            tx_vote_next   = tx_low;
        end
        else
        begin
            rx_vote_next = rx_dec;
            tx_vote_next = tx_dec;
            if (target > cur_vote_reg)
            begin
                cur_vote_next  = target;
                issued         = 1'b1;
                countdown_next = reload;
            end
            else if (target < cur_vote_reg)
            begin
                if (countdown_reg != '0)
                begin
                    countdown_next = countdown_reg - bwv_pkg::DELAY_W'(1);
                end
                else
                begin
                    cur_vote_next  = target;
                    issued         = 1'b1;
                    countdown_next = reload;
                end
            end
            else
            begin
                countdown_next = reload;
            end
        end
    end

    assign vote_bw = cur_vote_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_vote_reg   <= '0;
            tx_vote_reg   <= '0;
            cur_vote_reg  <= '0;
            countdown_reg <= '0;
        end
        else if (step)
        begin
            rx_vote_reg   <= rx_vote_next;
            tx_vote_reg   <= tx_vote_next;
            cur_vote_reg  <= cur_vote_next;
            countdown_reg <= countdown_next;
        end
    end

endmodule

>>> rtl/bandwidth_vote_hysteresis.sv
// ----------------------------------------------------------------------------
// bandwidth_vote_hysteresis
// Memory bandwidth vote with per-path hysteresis and delayed scale-down.
// a tick transaction is held in the input register, then the output register, before its vote transaction
// throughput: one tick per cycle while the vote channel does not stall, set by the single-pass vote update logic
// an input register and an output register decouple the two channels
// reset: asynchronous active low, clears config, votes, countdown and valids
// ----------------------------------------------------------------------------
module bandwidth_vote_hysteresis #(
    parameter int VOTE_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bwv_tick_if.sink             tick,
    bwv_vote_if.source           vote,
    bwv_cfg_if.sink              cfg
);

    bwv_pkg::vote_cfg_t               cfg_reg;
    logic [bwv_pkg::CHANNEL_W-1:0]    channel_reg;

    bwv_pkg::tick_item_t              item_reg;
    logic                             item_full_reg;
    logic                             out_full_reg;
    logic                             out_issued_reg;
    logic [VOTE_WIDTH-1:0]            out_bw_reg;
    logic [bwv_pkg::CHANNEL_W-1:0]    out_channel_reg;

    logic                             out_free;
    logic                             advance;
    logic                             step_issued;
    logic [VOTE_WIDTH-1:0]            step_bw;

    assign cfg.ready  = 1'b1;
    assign out_free   = !out_full_reg || vote.ready;
    assign advance    = item_full_reg && out_free;
    assign tick.ready = !item_full_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= '0;
            channel_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (bwv_pkg::cfg_reg_t'(cfg.index))
                bwv_pkg::REG_SCALE_DOWN_DELAY:
                    cfg_reg.scale_down_delay <= cfg.data[bwv_pkg::DELAY_W-1:0];
                bwv_pkg::REG_RX_HIGH_THRESH:
                    cfg_reg.rx.high_thresh <= cfg.data[bwv_pkg::THRESH_W-1:0];
                bwv_pkg::REG_RX_LOW_THRESH:
                    cfg_reg.rx.low_thresh <= cfg.data[bwv_pkg::THRESH_W-1:0];
                bwv_pkg::REG_TX_HIGH_THRESH:
                    cfg_reg.tx.high_thresh <= cfg.data[bwv_pkg::THRESH_W-1:0];
                bwv_pkg::REG_TX_LOW_THRESH:
                    cfg_reg.tx.low_thresh <= cfg.data[bwv_pkg::THRESH_W-1:0];
                bwv_pkg::REG_RX_VOTE_LEVELS:
                    cfg_reg.rx.levels <= cfg.data[bwv_pkg::LEVELS_W-1:0];
                bwv_pkg::REG_TX_VOTE_LEVELS:
                    cfg_reg.tx.levels <= cfg.data[bwv_pkg::LEVELS_W-1:0];
                bwv_pkg::REG_VOTE_CHANNEL_ID:
                    channel_reg <= cfg.data[bwv_pkg::CHANNEL_W-1:0];
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_full_reg <= 1'b0;
        end
        else if (tick.valid && tick.ready)
        begin
            item_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            item_reg.enable          <= tick.enable;
            item_reg.tick_shift      <= tick.tick_shift;
            item_reg.rx_normal_count <= tick.rx_normal_count;
            item_reg.rx_frag_count   <= tick.rx_frag_count;
            item_reg.tx_desc_count   <= tick.tx_desc_count;
        end
    end

    bwv_vote_ctrl #(.VOTE_WIDTH(VOTE_WIDTH)) u_vote_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .issued  (step_issued),
        .vote_bw (step_bw)
    );

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_full_reg <= 1'b1;
        end
        else if (vote.ready)
        begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_issued_reg  <= step_issued;
            out_bw_reg      <= step_bw;
            out_channel_reg <= channel_reg;
        end
    end

    assign vote.valid        = out_full_reg;
    assign vote.vote_issued  = out_issued_reg;
    assign vote.vote_bw      = out_bw_reg;
    assign vote.vote_channel = out_channel_reg;

endmodule

>>> rtl/bwv_checker.sv
// ----------------------------------------------------------------------------
// bwv_checker
// Port-level checks for the bandwidth vote block, bound to the top level.
// ----------------------------------------------------------------------------
module bwv_checker #(
    parameter int VOTE_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_valid,
    input  logic                  tick_ready,
    input  logic                  vote_valid,
    input  logic                  vote_ready,
    input  logic                  vote_issued,
    input  logic [VOTE_WIDTH-1:0] vote_bw
);

    logic tick_xact;
    logic vote_xact;

    assign tick_xact = tick_valid && tick_ready;
    assign vote_xact = vote_valid && vote_ready;

    // a pending vote is not withdrawn
    a_vote_held: assert property (@(posedge clk) disable iff (!rst_n)
        vote_valid && !vote_ready |=> vote_valid)
        else $error("vote valid dropped while stalled");

    // vote stays unchanged across back-to-back results without a new vote
    a_vote_kept: assert property (@(posedge clk) disable iff (!rst_n)
        vote_xact ##1 (vote_xact && !vote_issued) |-> vote_bw == $past(vote_bw))
        else $error("vote changed without being issued");

    // an accepted tick reaches the vote output through the input and result registers when not stalled
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        tick_xact ##1 vote_ready |=> vote_valid)
        else $error("vote transaction missing after tick");

    // input side drains when output side is free
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !tick_valid && vote_ready |=> tick_ready)
        else $error("tick channel stalled with free output");

endmodule

bind bandwidth_vote_hysteresis bwv_checker #(.VOTE_WIDTH(VOTE_WIDTH)) u_bwv_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_valid  (tick.valid),
    .tick_ready  (tick.ready),
    .vote_valid  (vote.valid),
    .vote_ready  (vote.ready),
    .vote_issued (vote.vote_issued),
    .vote_bw     (vote.vote_bw)
);

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives tick transactions and config writes into bandwidth_vote_hysteresis
// and checks every vote transaction against a cycle-free predictor of the
// per-path hysteresis, vote selection and delayed scale-down countdown.
// Runs a directed sequence, then random runs near and away from thresholds
// under several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

    localparam int VOTE_WIDTH  = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 200;
    localparam int DESC_BYTES  = bwv_pkg::SKB_BYTES / 2;

    typedef struct packed {
        logic                           issued;
        logic [VOTE_WIDTH-1:0]          bw;
        logic [bwv_pkg::CHANNEL_W-1:0]  channel;
    } vote_result_t;

    typedef struct packed {
        bwv_pkg::cfg_reg_t              index;
        logic [bwv_pkg::CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic clk = 1'b0;
    logic rst_n;

    bwv_tick_if                          tick_ch ();
    bwv_vote_if #(.VOTE_WIDTH(VOTE_WIDTH)) vote_ch ();
    bwv_cfg_if                           cfg_ch ();

    bandwidth_vote_hysteresis #(
        .VOTE_WIDTH (VOTE_WIDTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick_ch),
        .vote  (vote_ch),
        .cfg   (cfg_ch)
    );

    // predictor state and register shadow
    bwv_pkg::vote_cfg_t             vote_settings    = '0;
    logic [bwv_pkg::CHANNEL_W-1:0]  channel_setting  = '0;
    logic [VOTE_WIDTH-1:0]          rx_vote          = '0;
    logic [VOTE_WIDTH-1:0]          tx_vote          = '0;
    logic [VOTE_WIDTH-1:0]          held_vote        = '0;
    logic [bwv_pkg::DELAY_W-1:0]    scale_down_count = '0;

    bwv_pkg::tick_item_t pending_ticks[$];
    reg_write_t          pending_writes[$];
    vote_result_t        expected_votes[$];

    bwv_pkg::tick_item_t queued_tick;
    bwv_pkg::tick_item_t offered_tick;
    reg_write_t          queued_write;
    vote_result_t        want;

    int tick_gap_max;
    int vote_stall_max;
    int tick_idle;
    int vote_wait;
    int vote_pause;
    int hold_left;
    bit long_hold_armed;
    bit hold_served;
    int failures    = 0;
    int cycle_count = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [VOTE_WIDTH-1:0] path_vote(input logic [VOTE_WIDTH-1:0] prev,
                                                        input logic [31:0] bytes,
                                                        input bwv_pkg::path_cfg_t p);
        if (bytes > 32'(p.high_thresh) * 32'(bwv_pkg::MBPS_TO_BPMS))
            return p.levels[16 +: VOTE_WIDTH];
        if (bytes < 32'(p.low_thresh) * 32'(bwv_pkg::MBPS_TO_BPMS))
            return p.levels[VOTE_WIDTH-1:0];
        return prev;
    endfunction

    function automatic vote_result_t advance_vote(input bwv_pkg::tick_item_t t);
        vote_result_t                r;
        logic [bwv_pkg::DELAY_W-1:0] reload;
        logic [VOTE_WIDTH-1:0]       target;
        logic [31:0]                 rx_rate_bpms;
        logic [31:0]                 tx_rate_bpms;
        r.issued = 1'b0;
        if (!t.enable)
        begin
            if (held_vote != '0)
            begin
                held_vote = '0;
                r.issued  = 1'b1;
            end
            scale_down_count = '0;
            rx_vote = vote_settings.rx.levels[VOTE_WIDTH-1:0];
            tx_vote = vote_settings.tx.levels[VOTE_WIDTH-1:0];
        end
        else
        begin
            reload = vote_settings.scale_down_delay >> t.tick_shift;
            if (reload == '0)
                reload = bwv_pkg::DELAY_W'(1);
            rx_rate_bpms = 32'(t.rx_normal_count) * 32'(bwv_pkg::SKB_BYTES)
                         + 32'(t.rx_frag_count) * 32'(bwv_pkg::FRAG_BYTES);
            tx_rate_bpms = (32'(t.tx_desc_count) * 32'(bwv_pkg::SKB_BYTES)) >> 1;
            rx_vote  = path_vote(rx_vote, rx_rate_bpms, vote_settings.rx);
            tx_vote  = path_vote(tx_vote, tx_rate_bpms, vote_settings.tx);
            target   = (rx_vote > tx_vote) ? rx_vote : tx_vote;
            if (target > held_vote)
            begin
                held_vote        = target;
                r.issued         = 1'b1;
                scale_down_count = reload;
            end
            else if (target < held_vote)
            begin
                if (scale_down_count != '0)
                    scale_down_count = scale_down_count - 1'b1;
                else
                begin
                    held_vote        = target;
                    r.issued         = 1'b1;
                    scale_down_count = reload;
                end
            end
            else
                scale_down_count = reload;
        end
        r.bw      = held_vote;
        r.channel = channel_setting;
        return r;
    endfunction

    // tick driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ch.valid           <= 1'b0;
            tick_ch.enable          <= 1'b0;
            tick_ch.tick_shift      <= '0;
            tick_ch.rx_normal_count <= '0;
            tick_ch.rx_frag_count   <= '0;
            tick_ch.tx_desc_count   <= '0;
            offered_tick            <= '0;
            tick_idle               <= 0;
        end
        else
        begin
            if (tick_ch.valid && tick_ch.ready)
                expected_votes.push_back(advance_vote(offered_tick));
            if (!tick_ch.valid || tick_ch.ready)
            begin
                if (tick_idle != 0)
                begin
                    tick_idle     <= tick_idle - 1;
                    tick_ch.valid <= 1'b0;
                end
                else if (pending_ticks.size() != 0)
                begin
                    queued_tick = pending_ticks.pop_front();
                    tick_ch.valid           <= 1'b1;
                    tick_ch.enable          <= queued_tick.enable;
                    tick_ch.tick_shift      <= queued_tick.tick_shift;
                    tick_ch.rx_normal_count <= queued_tick.rx_normal_count;
                    tick_ch.rx_frag_count   <= queued_tick.rx_frag_count;
                    tick_ch.tx_desc_count   <= queued_tick.tx_desc_count;
                    offered_tick            <= queued_tick;
                    tick_idle               <= $urandom_range(tick_gap_max, 0);
                end
                else
                    tick_ch.valid <= 1'b0;
            end
        end
    end

    // config write driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.index <= '0;
            cfg_ch.data  <= '0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (bwv_pkg::cfg_reg_t'(cfg_ch.index))
                    bwv_pkg::REG_SCALE_DOWN_DELAY:
                        vote_settings.scale_down_delay = cfg_ch.data[bwv_pkg::DELAY_W-1:0];
                    bwv_pkg::REG_RX_HIGH_THRESH:
                        vote_settings.rx.high_thresh = cfg_ch.data[bwv_pkg::THRESH_W-1:0];
                    bwv_pkg::REG_RX_LOW_THRESH:
                        vote_settings.rx.low_thresh = cfg_ch.data[bwv_pkg::THRESH_W-1:0];
                    bwv_pkg::REG_TX_HIGH_THRESH:
                        vote_settings.tx.high_thresh = cfg_ch.data[bwv_pkg::THRESH_W-1:0];
                    bwv_pkg::REG_TX_LOW_THRESH:
                        vote_settings.tx.low_thresh = cfg_ch.data[bwv_pkg::THRESH_W-1:0];
                    bwv_pkg::REG_RX_VOTE_LEVELS:
                        vote_settings.rx.levels = cfg_ch.data;
                    bwv_pkg::REG_TX_VOTE_LEVELS:
                        vote_settings.tx.levels = cfg_ch.data;
                    bwv_pkg::REG_VOTE_CHANNEL_ID:
                        channel_setting = cfg_ch.data[bwv_pkg::CHANNEL_W-1:0];
                    default: ;
                endcase
            end
            if (!cfg_ch.valid || cfg_ch.ready)
            begin
                if (pending_writes.size() != 0)
                begin
                    queued_write = pending_writes.pop_front();
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.index <= queued_write.index;
                    cfg_ch.data  <= queued_write.data;
                end
                else
                    cfg_ch.valid <= 1'b0;
            end
        end
    end

    // vote monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vote_ch.ready <= 1'b0;
            vote_wait     <= 0;
            hold_left     <= 0;
            hold_served   <= 1'b0;
        end
        else
        begin
            if (vote_ch.valid && vote_ch.ready)
            begin
                if (expected_votes.size() == 0)
                begin
                    $error("vote transaction with no tick outstanding: %s %0d %0d %0d",
                           "issued bw channel", vote_ch.vote_issued, vote_ch.vote_bw,
                           vote_ch.vote_channel);
                    failures = failures + 1;
                end
                else
                begin
                    want = expected_votes.pop_front();
                    if (vote_ch.vote_issued !== want.issued)
                    begin
                        $error("vote_issued: expected %0d, actual %0d",
                               want.issued, vote_ch.vote_issued);
                        failures = failures + 1;
                    end
                    if (vote_ch.vote_bw !== want.bw)
                    begin
                        $error("vote_bw: expected %0d, actual %0d", want.bw, vote_ch.vote_bw);
                        failures = failures + 1;
                    end
                    if (vote_ch.vote_channel !== want.channel)
                    begin
                        $error("vote_channel: expected %0d, actual %0d",
                               want.channel, vote_ch.vote_channel);
                        failures = failures + 1;
                    end
                end
            end
            if (long_hold_armed && !hold_served)
            begin
                hold_served   <= 1'b1;
                hold_left     <= LONG_HOLD;
                vote_ch.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left     <= hold_left - 1;
                vote_ch.ready <= 1'b0;
            end
            else if (vote_ch.valid && vote_ch.ready)
            begin
                vote_pause = $urandom_range(vote_stall_max, 0);
                vote_wait     <= vote_pause;
                vote_ch.ready <= (vote_pause == 0);
            end
            else if (vote_wait != 0)
            begin
                vote_wait     <= vote_wait - 1;
                vote_ch.ready <= (vote_wait == 1);
            end
            else
                vote_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic push_tick(input logic en, input int shift, input int normal,
                             input int frag, input int desc);
        bwv_pkg::tick_item_t t;
        t.enable          = en;
        t.tick_shift      = shift[bwv_pkg::SHIFT_W-1:0];
        t.rx_normal_count = normal[bwv_pkg::COUNT_W-1:0];
        t.rx_frag_count   = frag[bwv_pkg::COUNT_W-1:0];
        t.tx_desc_count   = desc[bwv_pkg::COUNT_W-1:0];
        pending_ticks.push_back(t);
    endtask

    task automatic wait_idle();
        while (pending_ticks.size() != 0 || tick_ch.valid || expected_votes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_config(input logic [15:0] delay, input logic [15:0] rx_hi,
                               input logic [15:0] rx_lo, input logic [15:0] tx_hi,
                               input logic [15:0] tx_lo, input logic [31:0] rx_levels,
                               input logic [31:0] tx_levels, input logic [7:0] chan);
        pending_writes.push_back('{bwv_pkg::REG_SCALE_DOWN_DELAY, 32'(delay)});
        pending_writes.push_back('{bwv_pkg::REG_RX_HIGH_THRESH, 32'(rx_hi)});
        pending_writes.push_back('{bwv_pkg::REG_RX_LOW_THRESH, 32'(rx_lo)});
        pending_writes.push_back('{bwv_pkg::REG_TX_HIGH_THRESH, 32'(tx_hi)});
        pending_writes.push_back('{bwv_pkg::REG_TX_LOW_THRESH, 32'(tx_lo)});
        pending_writes.push_back('{bwv_pkg::REG_RX_VOTE_LEVELS, rx_levels});
        pending_writes.push_back('{bwv_pkg::REG_TX_VOTE_LEVELS, tx_levels});
        pending_writes.push_back('{bwv_pkg::REG_VOTE_CHANNEL_ID, 32'(chan)});
        @(posedge clk);
        while (pending_writes.size() != 0 || cfg_ch.valid)
            @(posedge clk);
    endtask

    // count within 3 of the one whose byte rate matches a threshold, clamped to 16 bits
    function automatic logic [bwv_pkg::COUNT_W-1:0] count_near(
        input logic [bwv_pkg::THRESH_W-1:0] mbps,
        input int unit_bytes);
        int base;
        int jitter;
        jitter = $urandom_range(6, 0);
        base = (int'(mbps) * bwv_pkg::MBPS_TO_BPMS) / unit_bytes + jitter - 3;
        if (base < 0)
            base = 0;
        if (base > 65535)
            base = 65535;
        return base[bwv_pkg::COUNT_W-1:0];
    endfunction

    task automatic queue_random_ticks(input int count, input int shift_lo, input int shift_hi);
        bwv_pkg::tick_item_t t;
        int regime;
        int run_left;
        logic [bwv_pkg::THRESH_W-1:0] rx_th;
        logic [bwv_pkg::THRESH_W-1:0] tx_th;
        regime   = 0;
        run_left = 0;
        for (int k = 0; k < count; k++)
        begin
            if (run_left == 0)
            begin
                regime   = $urandom_range(5, 0);
                run_left = $urandom_range(12, 1);
            end
            run_left = run_left - 1;
            t.enable     = ($urandom_range(15, 0) != 0);
            t.tick_shift = ($urandom_range(3, 0) == 0)
                         ? bwv_pkg::SHIFT_W'($urandom_range(31, 0))
                         : bwv_pkg::SHIFT_W'($urandom_range(shift_hi, shift_lo));
            rx_th = ($urandom_range(1, 0) != 0) ? vote_settings.rx.high_thresh
                                                : vote_settings.rx.low_thresh;
            tx_th = ($urandom_range(1, 0) != 0) ? vote_settings.tx.high_thresh
                                                : vote_settings.tx.low_thresh;
            if (regime == 2)
            begin
                rx_th = vote_settings.rx.high_thresh;
                tx_th = vote_settings.tx.high_thresh;
            end
            else if (regime == 3)
            begin
                rx_th = vote_settings.rx.low_thresh;
                tx_th = vote_settings.tx.low_thresh;
            end
            case (regime)
                0:
                begin
                    t.rx_normal_count = bwv_pkg::COUNT_W'($urandom);
                    t.rx_frag_count   = bwv_pkg::COUNT_W'($urandom);
                    t.tx_desc_count   = bwv_pkg::COUNT_W'($urandom);
                end
                1:
                begin
                    t.rx_normal_count = bwv_pkg::COUNT_W'($urandom_range(3, 0));
                    t.rx_frag_count   = bwv_pkg::COUNT_W'($urandom_range(1, 0));
                    t.tx_desc_count   = bwv_pkg::COUNT_W'($urandom_range(3, 0));
                end
                4:
                begin
                    t.rx_normal_count = ($urandom_range(1, 0) != 0) ? 16'hFFFF : 16'($urandom);
                    t.rx_frag_count   = ($urandom_range(1, 0) != 0) ? 16'hFFFF : 16'($urandom);
                    t.tx_desc_count   = ($urandom_range(1, 0) != 0) ? 16'hFFFF : 16'($urandom);
                end
                default:
                begin
                    if ($urandom_range(2, 0) != 0)
                    begin
                        t.rx_normal_count = count_near(rx_th, bwv_pkg::SKB_BYTES);
                        t.rx_frag_count   = '0;
                    end
                    else
                    begin
                        t.rx_normal_count = '0;
                        t.rx_frag_count   = count_near(rx_th, bwv_pkg::FRAG_BYTES);
                    end
                    t.tx_desc_count = count_near(tx_th, DESC_BYTES);
                end
            endcase
            pending_ticks.push_back(t);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        tick_ch.valid           = 1'b0;
        tick_ch.enable          = 1'b0;
        tick_ch.tick_shift      = '0;
        tick_ch.rx_normal_count = '0;
        tick_ch.rx_frag_count   = '0;
        tick_ch.tx_desc_count   = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = '0;
        cfg_ch.data             = '0;
        vote_ch.ready           = 1'b0;
        tick_gap_max            = 10;
        vote_stall_max          = 10;
        long_hold_armed         = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: rates at thresholds, countdown, shift extremes, disable
        load_config(16'd4, 16'd1536, 16'd768, 16'd768, 16'd384,
                    {16'd800, 16'd100}, {16'd600, 16'd50}, 8'hA5);
        push_tick(1'b1, 0, 0, 0, 0);
        push_tick(1'b1, 0, 125, 0, 0);
        push_tick(1'b1, 0, 126, 0, 0);
        push_tick(1'b1, 0, 0, 0, 125);
        push_tick(1'b1, 0, 0, 0, 0);
        push_tick(1'b1, 0, 0, 0, 0);
        push_tick(1'b1, 0, 0, 0, 0);
        push_tick(1'b1, 0, 0, 0, 0);
        push_tick(1'b1, 0, 0, 0, 65535);
        push_tick(1'b1, 31, 0, 0, 0);
        push_tick(1'b1, 31, 65535, 65535, 0);
        push_tick(1'b1, 31, 0, 0, 0);
        push_tick(1'b1, 31, 0, 0, 0);
        push_tick(1'b1, 0, 0, 50, 0);
        push_tick(1'b0, 5, 65535, 65535, 65535);
        push_tick(1'b0, 0, 0, 0, 0);
        push_tick(1'b1, 0, 0, 65535, 0);
        push_tick(1'b1, 16, 65535, 0, 65535);
        push_tick(1'b1, 21, 43690, 21845, 21845);
        push_tick(1'b0, 31, 0, 0, 0);
        wait_idle();

        // no idling on either side
        tick_gap_max   = 0;
        vote_stall_max = 0;
        queue_random_ticks(120, 0, 2);
        wait_idle();

        // all registers at their maximum
        tick_gap_max   = 10;
        vote_stall_max = 10;
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        queue_random_ticks(80, 11, 15);
        wait_idle();

        // crossed thresholds, zero delay, long receiver hold
        tick_gap_max   = 0;
        vote_stall_max = 3;
        load_config(16'd0, 16'd500, 16'd2000, 16'd300, 16'd1200,
                    {16'd1000, 16'd200}, {16'd1500, 16'd10}, 8'h3C);
        push_tick(1'b1, 0, 100, 0, 0);
        push_tick(1'b1, 0, 0, 0, 100);
        push_tick(1'b1, 3, 0, 0, 0);
        long_hold_armed = 1'b1;
        queue_random_ticks(100, 0, 31);
        wait_idle();

        // all registers zero
        tick_gap_max   = 10;
        vote_stall_max = 0;
        load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0, 8'd0);
        queue_random_ticks(40, 0, 31);
        wait_idle();

        // random settings, sender drains halfway through
        vote_stall_max = 10;
        load_config(16'($urandom_range(300, 0)), 16'($urandom_range(3000, 0)),
                    16'($urandom_range(3000, 0)), 16'($urandom_range(3000, 0)),
                    16'($urandom_range(3000, 0)), $urandom, $urandom,
                    8'($urandom_range(255, 0)));
        queue_random_ticks(50, 0, 4);
        wait_idle();
        queue_random_ticks(50, 0, 4);
        wait_idle();

        tick_gap_max = 3;
        load_config(16'($urandom_range(40, 1)), 16'($urandom_range(6000, 0)),
                    16'($urandom_range(6000, 0)), 16'($urandom_range(6000, 0)),
                    16'($urandom_range(6000, 0)), $urandom, $urandom,
                    8'($urandom_range(255, 0)));
        queue_random_ticks(110, 0, 3);
        wait_idle();

        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
